>>> hw/rtl/ftfp_pkg.sv
// Package for the fixed-timestep frame planner.
// Holds widths, register indexes, reset values and the types used across the modules.
// Depends on nothing.
package ftfp_pkg;

  localparam int TIME_W      = 31;
  localparam int SUM_W       = 32;
  localparam int FRAC_W      = 16;
  localparam int STEPS_W     = 8;
  localparam int CNT_W       = 6;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 32;

  localparam logic [CNT_W-1:0] STEP_ITERS = 6'd32;
  localparam logic [CNT_W-1:0] FRAC_ITERS = 6'd16;

  localparam logic [TIME_W-1:0]  STEP_LENGTH_RESET     = 31'd16666667;
  localparam logic [TIME_W-1:0]  MAX_FRAME_DELTA_RESET = 31'd250000000;
  localparam logic [STEPS_W-1:0] MAX_STEPS_RESET       = 8'd8;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_STEP_LENGTH     = 2'd0,
    REG_MAX_FRAME_DELTA = 2'd1,
    REG_MAX_STEPS       = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [TIME_W-1:0]  step_len;
    logic [TIME_W-1:0]  max_frame_delta;
    logic [STEPS_W-1:0] max_steps;
  } cfg_t;

  typedef struct packed {
    logic              start;
    logic [TIME_W-1:0] rem_init;
    logic [SUM_W-1:0]  dividend;
    logic [CNT_W-1:0]  iterations;
  } div_req_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_STEPS,
    ST_FRAC,
    ST_PUBLISH
  } fsm_state_t;

endpackage

>>> hw/rtl/ftfp_cfg_regs.sv
// Configuration registers of the frame planner with their write port.
// Presents the step length with zero taken as one. Depends on ftfp_pkg.
module ftfp_cfg_regs (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [ftfp_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [ftfp_pkg::CFG_DATA_W-1:0]    cfg_data,
  output ftfp_pkg::cfg_t                     cfg
);

  logic [ftfp_pkg::TIME_W-1:0]  step_length;
  logic [ftfp_pkg::TIME_W-1:0]  max_frame_delta;
  logic [ftfp_pkg::STEPS_W-1:0] max_steps;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_length     <= ftfp_pkg::STEP_LENGTH_RESET;
      max_frame_delta <= ftfp_pkg::MAX_FRAME_DELTA_RESET;
      max_steps       <= ftfp_pkg::MAX_STEPS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        ftfp_pkg::REG_STEP_LENGTH: begin
          step_length <= cfg_data[ftfp_pkg::TIME_W-1:0];
        end
        ftfp_pkg::REG_MAX_FRAME_DELTA: begin
          max_frame_delta <= cfg_data[ftfp_pkg::TIME_W-1:0];
        end
        ftfp_pkg::REG_MAX_STEPS: begin
          max_steps <= cfg_data[ftfp_pkg::STEPS_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    cfg.step_len        = (step_length == '0) ? {{(ftfp_pkg::TIME_W-1){1'b0}}, 1'b1}
                                              : step_length;
    cfg.max_frame_delta = max_frame_delta;
    cfg.max_steps       = max_steps;
  end

endmodule

>>> hw/rtl/ftfp_divider.sv
// Shared restoring divider, one quotient bit per cycle.
// Starts from a given partial remainder, which must be below the divisor. Depends on ftfp_pkg.
module ftfp_divider (
  input  logic                         clk,
  input  logic                         rst,
  input  ftfp_pkg::div_req_t           req,
  input  logic [ftfp_pkg::TIME_W-1:0]  divisor,
  output logic                         busy,
  output logic                         done,
  output logic [ftfp_pkg::SUM_W-1:0]   quotient,
  output logic [ftfp_pkg::TIME_W-1:0]  remainder
);

  logic [ftfp_pkg::TIME_W-1:0] rem;
  logic [ftfp_pkg::TIME_W-1:0] rem_next;
  logic [ftfp_pkg::SUM_W-1:0]  quo;
  logic [ftfp_pkg::SUM_W-1:0]  quo_next;
  logic [ftfp_pkg::CNT_W-1:0]  count;
  logic [ftfp_pkg::SUM_W-1:0]  trial;
  logic [ftfp_pkg::SUM_W-1:0]  diff;
  logic                        fits;

  always_comb begin
    trial    = {rem, quo[ftfp_pkg::SUM_W-1]};
    diff     = trial - {1'b0, divisor};
    fits     = trial >= {1'b0, divisor};
    rem_next = fits ? diff[ftfp_pkg::TIME_W-1:0] : trial[ftfp_pkg::TIME_W-1:0];
    quo_next = {quo[ftfp_pkg::SUM_W-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        count <= req.iterations;
      end else if (busy) begin
        count <= count - 1'b1;
        if (count == {{(ftfp_pkg::CNT_W-1){1'b0}}, 1'b1}) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= req.rem_init;
      quo <= req.dividend;
    end else if (busy) begin
      rem <= rem_next;
      quo <= quo_next;
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

`ifndef SYNTHESIS
  a_start_when_free: assert property (@(posedge clk) disable iff (rst)
    req.start |-> !busy) else $error("divider started while busy");
  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    busy |-> (rem < divisor)) else $error("partial remainder not below divisor");
  a_done_after_last: assert property (@(posedge clk) disable iff (rst)
    (busy && !req.start && count == {{(ftfp_pkg::CNT_W-1){1'b0}}, 1'b1}) |=> (done && !busy))
    else $error("divider did not finish after its last iteration");
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("done raised while still busy");
`endif

endmodule

>>> hw/rtl/fixed_timestep_frame_planner_core.sv
// Top level of the fixed-timestep frame planner.
// Holds the sequencer, the leftover time and the result register; instantiates
// ftfp_cfg_regs and ftfp_divider. Depends on ftfp_pkg.
//
// Usage: each transfer on the input channel carries one signed frame time.
// It is clamped to zero and max_frame_delta, added to the leftover time, and
// divided by the step length in one shared bit-serial divider, first for
// the step count and remainder, then for the Q0.16 blend fraction. The input
// channel is not ready while an item is in work, so the block takes a new
// item only once the last one's result has moved into the output register.
// The result sits in an output register, so a new input item is taken while
// that result still waits; if the receiver stalls past the next item's
// divisions, the sequencer holds the finished result until the register frees.
// The configuration channel is always ready; the user must write it only
// while idle, which the block does not enforce. Synchronous reset loads the
// register defaults, clears the leftover time and empties the output register.
module fixed_timestep_frame_planner_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [31:0]                 frame_time,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [ftfp_pkg::TIME_W-1:0]        used_delta,
  output logic [ftfp_pkg::STEPS_W-1:0]       step_count,
  output logic [ftfp_pkg::FRAC_W-1:0]        blend_fraction,
  output logic                               was_clamped,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [ftfp_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [ftfp_pkg::CFG_DATA_W-1:0]    cfg_data
);

  ftfp_pkg::cfg_t              cfg;
  ftfp_pkg::div_req_t          div_req;
  ftfp_pkg::fsm_state_t        state;
  ftfp_pkg::fsm_state_t        state_next;
  logic                        div_busy;
  logic                        div_done;
  logic [ftfp_pkg::SUM_W-1:0]  div_quotient;
  logic [ftfp_pkg::TIME_W-1:0] div_remainder;

  logic [ftfp_pkg::TIME_W-1:0]  leftover;
  logic [ftfp_pkg::TIME_W-1:0]  used;
  logic                         delta_cut;
  logic [ftfp_pkg::STEPS_W-1:0] steps;
  logic                         steps_cut;
  logic [ftfp_pkg::FRAC_W-1:0]  frac;

  logic [ftfp_pkg::TIME_W-1:0]  safe_time;
  logic                         cut_now;
  logic [ftfp_pkg::TIME_W-1:0]  used_now;
  logic [ftfp_pkg::SUM_W-1:0]   sum_now;
  logic                         steps_over;
  logic                         in_fire;
  logic                         publish;

  ftfp_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ftfp_divider u_div (
    .clk       (clk),
    .rst       (rst),
    .req       (div_req),
    .divisor   (cfg.step_len),
    .busy      (div_busy),
    .done      (div_done),
    .quotient  (div_quotient),
    .remainder (div_remainder)
  );

  always_comb begin
    safe_time  = frame_time[31] ? '0 : frame_time[ftfp_pkg::TIME_W-1:0];
    cut_now    = safe_time > cfg.max_frame_delta;
    used_now   = cut_now ? cfg.max_frame_delta : safe_time;
    sum_now    = {1'b0, leftover} + {1'b0, used_now};
    steps_over = div_quotient > {{(ftfp_pkg::SUM_W-ftfp_pkg::STEPS_W){1'b0}}, cfg.max_steps};
    in_fire    = in_valid && in_ready;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ftfp_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = ftfp_pkg::ST_STEPS;
        end
      end
      ftfp_pkg::ST_STEPS: begin
        if (div_done) begin
          state_next = ftfp_pkg::ST_FRAC;
        end
      end
      ftfp_pkg::ST_FRAC: begin
        if (div_done) begin
          state_next = ftfp_pkg::ST_PUBLISH;
        end
      end
      ftfp_pkg::ST_PUBLISH: begin
        if (!out_valid || out_ready) begin
          state_next = ftfp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = ftfp_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready           = 1'b0;
    publish            = 1'b0;
    div_req.start      = 1'b0;
    div_req.rem_init   = '0;
    div_req.dividend   = sum_now;
    div_req.iterations = ftfp_pkg::STEP_ITERS;
    unique case (state)
      ftfp_pkg::ST_IDLE: begin
        in_ready      = 1'b1;
        div_req.start = in_valid;
      end
      ftfp_pkg::ST_STEPS: begin
        div_req.start      = div_done;
        div_req.rem_init   = div_remainder;
        div_req.dividend   = '0;
        div_req.iterations = ftfp_pkg::FRAC_ITERS;
      end
      ftfp_pkg::ST_FRAC: begin
      end
      ftfp_pkg::ST_PUBLISH: begin
        publish = !out_valid || out_ready;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ftfp_pkg::ST_IDLE;
      leftover  <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ftfp_pkg::ST_STEPS && div_done) begin
        leftover <= div_remainder;
      end
      if (publish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      used      <= used_now;
      delta_cut <= cut_now;
    end
    if (state == ftfp_pkg::ST_STEPS && div_done) begin
      steps_cut <= steps_over;
      steps     <= steps_over ? cfg.max_steps : div_quotient[ftfp_pkg::STEPS_W-1:0];
    end
    if (state == ftfp_pkg::ST_FRAC && div_done) begin
      frac <= div_quotient[ftfp_pkg::FRAC_W-1:0];
    end
    if (publish) begin
      used_delta     <= used;
      step_count     <= steps;
      blend_fraction <= frac;
      was_clamped    <= delta_cut || steps_cut;
    end
  end

`ifndef SYNTHESIS
  a_idle_divider_free: assert property (@(posedge clk) disable iff (rst)
    (state == ftfp_pkg::ST_IDLE) |-> !div_busy) else $error("divider busy while idle");
  a_leftover_below_len: assert property (@(posedge clk) disable iff (rst)
    (state == ftfp_pkg::ST_FRAC) |-> (leftover < cfg.step_len))
    else $error("leftover time not below step length");
  a_accept_starts_div: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> (div_busy && state == ftfp_pkg::ST_STEPS))
    else $error("input transfer did not start the step division");
`endif

endmodule
